// ===== design/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tpt assertion failed");

`define TPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpt implication failed");

`else

`define TPT_ASSERT(lbl, clk, rst_n, prop)

`define TPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/tpt_pkg.sv =====
`timescale 1ns / 1ps

package tpt_pkg;

    localparam int W_BITS       = 16;  // q8.8 weight, bias
    localparam int IN_BITS      = 16;  // feature bits carried by one word
    localparam int IDX_BITS     = 4;
    localparam int LEN_BITS     = 5;
    localparam int MODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [MODE_BITS-1:0] MODE_PREDICT     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_OPTIMISTIC  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PESSIMISTIC = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BIAS          = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LENGTH = 1'b1;

    localparam logic [LEN_BITS-1:0] ACTIVE_LENGTH_RST = 5'd16;

    typedef struct packed {
        logic use_unk;  // unknown features get completed
        logic pess;     // complete with negative weights, test below zero
    } t_mode_ctl;

    typedef struct packed {
        logic v1;
        logic v2;
        logic v3;
    } t_pipe_stat;

endpackage

// ===== design/tpt_in_if.sv =====
`timescale 1ns / 1ps

interface tpt_in_if import tpt_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [IDX_BITS-1:0]         weight_index;
    logic signed [W_BITS-1:0]    weight_value;
    logic [MODE_BITS-1:0]        mode;
    logic [IN_BITS-1:0]          feature_bits;
    logic [IN_BITS-1:0]          unknown_bits;

    modport source (
        output valid, op, weight_index, weight_value, mode, feature_bits, unknown_bits,
        input  ready
    );
    modport sink (
        input  valid, op, weight_index, weight_value, mode, feature_bits, unknown_bits,
        output ready
    );
endinterface

// ===== design/tpt_out_if.sv =====
`timescale 1ns / 1ps

interface tpt_out_if;
    logic valid;
    logic ready;
    logic decision;

    modport source (
        output valid, decision,
        input  ready
    );
    modport sink (
        input  valid, decision,
        output ready
    );
endinterface

// ===== design/tpt_lane.sv =====
`timescale 1ns / 1ps

module tpt_lane import tpt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic signed [W_BITS-1:0] i_wdata,
    input  t_mode_ctl                i_ctl,
    input  logic                     i_active,
    input  logic                     i_feat,
    input  logic                     i_unk,
    output logic signed [W_BITS-1:0] o_contrib
);

    logic signed [W_BITS-1:0] r_weight;
    logic                     w_pos;
    logic                     w_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_we) begin
            r_weight <= i_wdata;
        end
    end

    assign w_pos = (r_weight != '0) && !r_weight[W_BITS-1];

    always_comb begin
        if (i_ctl.use_unk && i_unk) begin
            w_counts = i_ctl.pess ? r_weight[W_BITS-1] : w_pos;
        end else begin
            w_counts = i_feat;
        end
    end

    assign o_contrib = (w_counts && i_active) ? r_weight : '0;

endmodule

// ===== design/tpt_merge.sv =====
`timescale 1ns / 1ps

module tpt_merge import tpt_pkg::*; #(
    parameter int FEATURES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_pess,
    input  logic signed [W_BITS-1:0] i_contrib [FEATURES],
    input  logic signed [W_BITS-1:0] i_bias,
    output logic                     o_ready,
    output t_pipe_stat               o_stat,
    tpt_out_if.source                o_result
);

    localparam int G1  = (FEATURES + 3) / 4;
    localparam int G2  = (G1 + 3) / 4;
    localparam int S1W = W_BITS + 2;
    localparam int S2W = W_BITS + 4;
    localparam int TW  = W_BITS + 6;
    localparam int SW  = TW + 1;

    logic signed [W_BITS-1:0] w_pad [G1*4];
    logic signed [S1W-1:0]    n_g1  [G1];
    logic signed [S1W-1:0]    w_g1p [G2*4];
    logic signed [S2W-1:0]    n_g2  [G2];
    logic signed [TW-1:0]     w_total;
    logic signed [SW-1:0]     w_biased;

    logic signed [S1W-1:0] r_g1 [G1];
    logic signed [S2W-1:0] r_g2 [G2];
    logic                  r_v1, r_v2, r_v3;
    logic                  r_pess1, r_pess2;
    logic                  r_decision;
    logic                  w_rdy1, w_rdy2, w_rdy3;

    genvar gi;
    generate
        for (gi = 0; gi < G1 * 4; gi++) begin : g_pad1
            if (gi < FEATURES) begin : g_real
                assign w_pad[gi] = i_contrib[gi];
            end else begin : g_zero
                assign w_pad[gi] = '0;
            end
        end
        for (gi = 0; gi < G2 * 4; gi++) begin : g_pad2
            if (gi < G1) begin : g_real
                assign w_g1p[gi] = r_g1[gi];
            end else begin : g_zero
                assign w_g1p[gi] = '0;
            end
        end
    endgenerate

    // first tree level: lanes in groups of four
    always_comb begin
        for (int g = 0; g < G1; g++) begin
            n_g1[g] = S1W'(w_pad[g*4]) + S1W'(w_pad[g*4+1])
                    + S1W'(w_pad[g*4+2]) + S1W'(w_pad[g*4+3]);
        end
    end

    always_comb begin
        for (int g = 0; g < G2; g++) begin
            n_g2[g] = S2W'(w_g1p[g*4]) + S2W'(w_g1p[g*4+1])
                    + S2W'(w_g1p[g*4+2]) + S2W'(w_g1p[g*4+3]);
        end
    end

    always_comb begin
        w_total = '0;
        for (int g = 0; g < G2; g++) begin
            w_total = w_total + TW'(r_g2[g]);
        end
        w_biased = SW'(w_total) + SW'(i_bias);
    end

    // each stage moves when it is empty or the one after it moves
    assign w_rdy3  = !r_v3 || o_result.ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_fire;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_fire) begin
            r_g1    <= n_g1;
            r_pess1 <= i_pess;
        end
        if (w_rdy2 && r_v1) begin
            r_g2    <= n_g2;
            r_pess2 <= r_pess1;
        end
        if (w_rdy3 && r_v2) begin
            // sum + bias below zero is the pessimistic test, else its negation
            r_decision <= r_pess2 ? w_biased[SW-1] : !w_biased[SW-1];
        end
    end

    assign o_result.valid    = r_v3;
    assign o_result.decision = r_decision;
    assign o_stat            = '{v1: r_v1, v2: r_v2, v3: r_v3};

endmodule

// ===== design/ternary_perceptron_threshold_core.sv =====
`timescale 1ns / 1ps
// channel    dir   handshake        word
// i_item     in    valid / ready    op, weight_index, weight_value, mode,
//                                   feature_bits, unknown_bits
// o_result   out   valid / ready    decision (one per evaluate word)
//
// one word per cycle while results are taken, loads and evaluates alike; a stalled result side holds it
// an evaluate word is answered through registered stages: lane masking and the
// first adder level, the second adder level, then the final add, bias and sign test
// a load word writes its lane weight at acceptance and gives no result
// synchronous reset clears weights and bias, active_length returns to 16
// a stalled result holds the last stage; earlier stages keep filling their bubbles

`include "assert_macros.svh"

module ternary_perceptron_threshold_core import tpt_pkg::*; #(
    parameter int FEATURES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [W_BITS-1:0]           i_cfg_data,
    tpt_in_if.sink                      i_item,
    tpt_out_if.source                   o_result
);

    logic signed [W_BITS-1:0] r_bias;
    logic [LEN_BITS-1:0]      r_active_length;

    logic                     w_fire;
    logic                     w_eval_fire;
    logic                     w_load_fire;
    logic                     w_ready;
    t_mode_ctl                w_ctl;
    t_pipe_stat               w_stat;
    logic signed [W_BITS-1:0] w_contrib [FEATURES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias          <= '0;
            r_active_length <= ACTIVE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BIAS:          r_bias          <= i_cfg_data;
                CFG_ACTIVE_LENGTH: r_active_length <= i_cfg_data[LEN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign i_item.ready = w_ready;
    assign w_fire       = i_item.valid && w_ready;
    assign w_eval_fire  = w_fire && (i_item.op == OP_EVAL);
    assign w_load_fire  = w_fire && (i_item.op == OP_LOAD);

    // unused mode code falls back to predict
    always_comb begin
        unique case (i_item.mode)
            MODE_OPTIMISTIC:  w_ctl = '{use_unk: 1'b1, pess: 1'b0};
            MODE_PESSIMISTIC: w_ctl = '{use_unk: 1'b1, pess: 1'b1};
            default:          w_ctl = '{use_unk: 1'b0, pess: 1'b0};
        endcase
    end

    genvar li;
    generate
        for (li = 0; li < FEATURES; li++) begin : g_lane
            logic w_we;
            logic w_feat;
            logic w_unk;
            logic w_active;

            // lanes past the input word see known zeros and no writes
            if (li < IN_BITS) begin : g_in
                assign w_we   = w_load_fire && (i_item.weight_index == IDX_BITS'(li));
                assign w_feat = i_item.feature_bits[li];
                assign w_unk  = i_item.unknown_bits[li];
            end else begin : g_out
                assign w_we   = 1'b0;
                assign w_feat = 1'b0;
                assign w_unk  = 1'b0;
            end

            assign w_active = ({1'b0, r_active_length} > (LEN_BITS + 1)'(li));

            tpt_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_we      (w_we),
                .i_wdata   (i_item.weight_value),
                .i_ctl     (w_ctl),
                .i_active  (w_active),
                .i_feat    (w_feat),
                .i_unk     (w_unk),
                .o_contrib (w_contrib[li])
            );
        end
    endgenerate

    tpt_merge #(
        .FEATURES (FEATURES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_eval_fire),
        .i_pess    (w_ctl.pess),
        .i_contrib (w_contrib),
        .i_bias    (r_bias),
        .o_ready   (w_ready),
        .o_stat    (w_stat),
        .o_result  (o_result)
    );

    // an evaluate word entering an empty pipeline surfaces as a valid result
    `TPT_ASSERT_IMP(a_eval_latency, i_clk, i_rst_n, w_eval_fire && !w_stat.v1 && !w_stat.v2 && !w_stat.v3, ##3 o_result.valid)
    // a load word never occupies a pipeline stage
    `TPT_ASSERT_IMP(a_load_no_slot, i_clk, i_rst_n, w_load_fire && !w_stat.v1, ##1 !w_stat.v1)
    // an empty first stage always takes a word
    `TPT_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !w_stat.v1, i_item.ready)

endmodule

// ===== test/tpt_decision_checker.sv =====
`timescale 1ns / 1ps

module tpt_decision_checker import tpt_pkg::*; #(
    parameter int FEATURES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [W_BITS-1:0]       i_cfg_data,
    input  logic                    i_item_valid,
    input  logic                    i_item_ready,
    input  logic                    i_op,
    input  logic [IDX_BITS-1:0]     i_weight_index,
    input  logic [W_BITS-1:0]       i_weight_value,
    input  logic [MODE_BITS-1:0]    i_mode,
    input  logic [IN_BITS-1:0]      i_feature_bits,
    input  logic [IN_BITS-1:0]      i_unknown_bits,
    input  logic                    i_result_valid,
    input  logic                    i_result_ready,
    input  logic                    i_decision,
    output int                      o_miss_count,
    output int                      o_pending
);

    localparam int REPORT_MAX = 10;

    logic signed [W_BITS-1:0] weight_mem [FEATURES];
    logic signed [W_BITS-1:0] bias_reg;
    logic [LEN_BITS-1:0]      length_reg;
    logic                     decision_q [$];
    int                       misses;

    // weighted sum over the active lanes, then the sign test of the mode
    function automatic logic threshold_decision(
        input logic [MODE_BITS-1:0] mode,
        input logic [IN_BITS-1:0]   feat,
        input logic [IN_BITS-1:0]   unk
    );
        int                   acc;
        int                   lanes;
        int                   w;
        int                   i;
        logic                 known_one;
        logic                 unknown;
        logic [MODE_BITS-1:0] m;
        acc = 0;
        m = (mode == MODE_OPTIMISTIC || mode == MODE_PESSIMISTIC) ? mode : MODE_PREDICT;
        lanes = (int'(length_reg) > FEATURES) ? FEATURES : int'(length_reg);
        for (i = 0; i < lanes; i++) begin
            w = int'(weight_mem[i]);
            // lanes past the input word read as known zeros
            known_one = (i < IN_BITS) ? feat[i] : 1'b0;
            unknown   = (i < IN_BITS) ? unk[i] : 1'b0;
            if (m != MODE_PREDICT && unknown) begin
                if (m == MODE_OPTIMISTIC && w > 0) begin
                    acc += w;
                end else if (m == MODE_PESSIMISTIC && w < 0) begin
                    acc += w;
                end
            end else if (known_one) begin
                acc += w;
            end
        end
        if (m == MODE_PESSIMISTIC) begin
            return (acc + int'(bias_reg)) < 0;
        end
        return (acc + int'(bias_reg)) >= 0;
    endfunction

    always @(posedge i_clk) begin : track
        int   i;
        logic want;
        if (!i_rst_n) begin
            for (i = 0; i < FEATURES; i++) begin
                weight_mem[i] = '0;
            end
            bias_reg = '0;
            length_reg = ACTIVE_LENGTH_RST;
            decision_q.delete();
            misses = 0;
            o_miss_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIAS: begin
                        bias_reg = i_cfg_data;
                    end
                    CFG_ACTIVE_LENGTH: begin
                        length_reg = i_cfg_data[LEN_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_result_valid && i_result_ready) begin
                if (decision_q.size() == 0) begin
                    misses++;
                    if (misses <= REPORT_MAX) begin
                        $display("unexpected decision word %0d, nothing pending", i_decision);
                    end
                end else begin
                    want = decision_q.pop_front();
                    if (i_decision !== want) begin
                        misses++;
                        if (misses <= REPORT_MAX) begin
                            $display("decision mismatch: expected %0d got %0d", want,
                                     i_decision);
                        end
                    end
                end
            end
            if (i_item_valid && i_item_ready) begin
                if (i_op == OP_LOAD) begin
                    if (int'(i_weight_index) < FEATURES) begin
                        weight_mem[i_weight_index] = i_weight_value;
                    end
                end else begin
                    decision_q.push_back(threshold_decision(i_mode, i_feature_bits,
                                                            i_unknown_bits));
                end
            end
            o_miss_count <= misses;
            o_pending <= decision_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tpt_pkg::*;

    localparam int GAP_MAX        = 18;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_LIMIT     = 3000;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 160;
    localparam int HOLD_PHASE     = 6;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [W_BITS-1:0]       cfg_data;
    int                      miss_count;
    int                      pending;
    int                      idle_cycles = 0;
    bit                      quiet_phase;
    bit                      rx_hold_req;

    tpt_in_if  item_ch ();
    tpt_out_if result_ch ();

    ternary_perceptron_threshold_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    tpt_decision_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_item_valid   (item_ch.valid),
        .i_item_ready   (item_ch.ready),
        .i_op           (item_ch.op),
        .i_weight_index (item_ch.weight_index),
        .i_weight_value (item_ch.weight_value),
        .i_mode         (item_ch.mode),
        .i_feature_bits (item_ch.feature_bits),
        .i_unknown_bits (item_ch.unknown_bits),
        .i_result_valid (result_ch.valid),
        .i_result_ready (result_ch.ready),
        .i_decision     (result_ch.decision),
        .o_miss_count   (miss_count),
        .o_pending      (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_wait();
        return quiet_phase ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // lean on the corner values now and then
    function automatic logic [W_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return W_BITS'($urandom);
        endcase
    endfunction

    task automatic send_word(
        input logic                 op,
        input logic [IDX_BITS-1:0]  idx,
        input logic [W_BITS-1:0]    val,
        input logic [MODE_BITS-1:0] mode,
        input logic [IN_BITS-1:0]   feat,
        input logic [IN_BITS-1:0]   unk
    );
        int gap;
        gap = pick_wait();
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.op           <= op;
        item_ch.weight_index <= idx;
        item_ch.weight_value <= val;
        item_ch.mode         <= mode;
        item_ch.feature_bits <= feat;
        item_ch.unknown_bits <= unk;
        item_ch.valid        <= 1'b1;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // drop valid and wait for the pipe to drain
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: random stall per word, one long hold on request
    initial begin : drain_side
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            @(negedge clk);
            if (rx_hold_req && !hold_taken) begin
                stall = RX_HOLD_CYCLES;
                hold_taken = 1'b1;
            end else begin
                stall = pick_wait();
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    initial begin : stimulus
        int                p;
        int                k;
        logic [W_BITS-1:0] bias_val;
        logic [LEN_BITS-1:0] len_val;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        quiet_phase          = 1'b0;
        rx_hold_req          = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_LOAD;
        item_ch.weight_index = '0;
        item_ch.weight_value = '0;
        item_ch.mode         = MODE_PREDICT;
        item_ch.feature_bits = '0;
        item_ch.unknown_bits = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // cleared weights: zero sum sits exactly on the threshold
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd0, 16'h7FFF, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd1, 16'h8000, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd15, 16'hFFFF, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd7, 16'h0001, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 4'd8, 16'hFFFE, MODE_PREDICT, 16'h0000, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PREDICT, 16'hFFFF, 16'hFFFF);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_OPTIMISTIC, 16'h0000, 16'hFFFF);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'h0000, 16'hFFFF);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_UNUSED, 16'h0003, 16'hFFFF);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_OPTIMISTIC, 16'hFFFF, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'h8000, 16'h0001);

        // zero length: nothing summed, bias alone decides
        settle();
        write_reg(CFG_BIAS, 16'h8000);
        write_reg(CFG_ACTIVE_LENGTH, 16'd0);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PREDICT, 16'hFFFF, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'hFFFF, 16'hFFFF);

        // length past the lane count clamps
        settle();
        write_reg(CFG_BIAS, 16'h7FFF);
        write_reg(CFG_ACTIVE_LENGTH, 16'd31);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_OPTIMISTIC, 16'h0000, 16'hFFFF);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'h0000, 16'hFFFF);

        settle();
        write_reg(CFG_BIAS, 16'h0001);
        write_reg(CFG_ACTIVE_LENGTH, 16'd1);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PREDICT, 16'h0001, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PREDICT, 16'h0002, 16'h0000);
        send_word(OP_EVAL, 4'd0, 16'h0000, MODE_PESSIMISTIC, 16'h0000, 16'h0001);

        for (p = 0; p < PHASES; p++) begin
            settle();
            @(posedge clk);
            quiet_phase = (p % 4 == 3) || (p == HOLD_PHASE);
            if (p == HOLD_PHASE) begin
                rx_hold_req = 1'b1;
            end
            case (p)
                0: bias_val = 16'h8000;
                1: bias_val = 16'h7FFF;
                default: bias_val = pick_word();
            endcase
            case (p)
                0: len_val = 5'd16;
                1: len_val = 5'd1;
                2: len_val = 5'd31;
                3: len_val = 5'd0;
                4: len_val = 5'd17;
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        len_val = LEN_BITS'($urandom_range(0, 31));
                    end else begin
                        len_val = LEN_BITS'($urandom_range(1, 16));
                    end
                end
            endcase
            write_reg(CFG_BIAS, bias_val);
            write_reg(CFG_ACTIVE_LENGTH, {{(W_BITS-LEN_BITS){1'b0}}, len_val});
            for (k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_word(OP_LOAD, IDX_BITS'($urandom_range(0, 15)), pick_word(),
                              MODE_BITS'($urandom_range(0, 3)), IN_BITS'($urandom),
                              IN_BITS'($urandom));
                end else begin
                    send_word(OP_EVAL, IDX_BITS'($urandom_range(0, 15)), W_BITS'($urandom),
                              MODE_BITS'($urandom_range(0, 3)), pick_word(),
                              ($urandom_range(0, 3) == 0) ? 16'h0000 : pick_word());
                end
            end
        end

        settle();
        if (miss_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== ternary_perceptron_threshold_core.f =====
+incdir+design
design/tpt_pkg.sv
design/tpt_in_if.sv
design/tpt_out_if.sv
design/tpt_lane.sv
design/tpt_merge.sv
design/ternary_perceptron_threshold_core.sv
test/tpt_decision_checker.sv
test/tb.sv
